// ===== hw/rtl/asa_pkg.sv =====
`timescale 1ns / 1ps

package asa_pkg;

    // Radius, doubled denominators and their magnitudes.
    localparam int RADIUS_W = 24;
    localparam int REG_W    = 16;
    localparam int DEN_W    = RADIUS_W + 2;

    // CORDIC datapath: x and y carry the integer magnitude shifted left by XY_SHIFT.
    localparam int XY_SHIFT  = 30;
    localparam int XY_W      = 58;
    localparam int ANG_FRAC  = 20;
    localparam int Z_W       = 29;
    localparam int ZC_W      = 27;
    localparam int PROD_W    = 34;
    localparam int CENT_W    = 14;
    localparam int TABLE_LEN = 24;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam int ANGLE_W = 15;
    localparam int GAP_W   = 16;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    localparam logic [CENT_W-1:0] CENT_MAX = CENT_W'(9000);
    localparam logic [ZC_W-1:0]   Z_MAX    = ZC_W'(90) << ANG_FRAC;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ANG_FRAC - 1);
    localparam logic [PROD_W-1:0] CENT_SCALE = PROD_W'(100);

    // Configuration register map.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_SPAN = 1'b1;
    localparam logic [REG_W-1:0] WHEEL_BASE_RST = REG_W'(3000);
    localparam logic [REG_W-1:0] TRACK_SPAN_RST = REG_W'(2000);

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
        logic                   dzero;
    } t_lane;

    typedef struct packed {
        logic  valid;
        logic  zr;
        t_lane inner;
        t_lane outer;
    } t_cstage;

    typedef struct packed {
        logic [CENT_W-1:0] cent;
        logic              neg;
        logic              dzero;
    } t_cent;

    typedef struct packed {
        logic  valid;
        logic  zr;
        t_cent inner;
        t_cent outer;
    } t_fin;

    // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
    function automatic int atan_entry(input int idx);
        int v;
        case (idx)
            0:  v = 47185920;
            1:  v = 27855475;
            2:  v = 14718068;
            3:  v = 7471121;
            4:  v = 3750058;
            5:  v = 1876857;
            6:  v = 938658;
            7:  v = 469357;
            8:  v = 234682;
            9:  v = 117342;
            10: v = 58671;
            11: v = 29335;
            12: v = 14668;
            13: v = 7334;
            14: v = 3667;
            15: v = 1833;
            16: v = 917;
            17: v = 458;
            18: v = 229;
            19: v = 115;
            20: v = 57;
            21: v = 29;
            22: v = 14;
            23: v = 7;
            default: v = 0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/asa_prep.sv =====
`timescale 1ns / 1ps

module asa_prep (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [asa_pkg::RADIUS_W-1:0]  i_radius,
    input  logic [asa_pkg::REG_W-1:0]            i_wheel_base,
    input  logic [asa_pkg::REG_W-1:0]            i_track_span,
    output asa_pkg::t_cstage                     o_stage
);
    import asa_pkg::*;

    logic signed [DEN_W-1:0] w_r2;
    logic signed [DEN_W-1:0] w_span;
    logic signed [DEN_W-1:0] w_den_in;
    logic signed [DEN_W-1:0] w_den_out;
    logic [REG_W:0]          w_num;
    t_lane                   n_inner;
    t_lane                   n_outer;
    logic                    n_zr;

    logic  r_valid;
    logic  r_zr;
    t_lane r_inner;
    t_lane r_outer;

    // Starting vector: x is the magnitude of the denominator, y the doubled wheelbase.
    function automatic t_lane start_lane(input logic signed [DEN_W-1:0] den,
                                         input logic [REG_W:0] num);
        t_lane a;
        logic [DEN_W-1:0] mag;
        mag     = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        a.x     = XY_W'(mag) << XY_SHIFT;
        a.y     = XY_W'(num) << XY_SHIFT;
        a.z     = '0;
        a.neg   = den[DEN_W-1];
        a.dzero = (den == '0);
        return a;
    endfunction

    always_comb begin
        w_r2      = DEN_W'(i_radius) <<< 1;
        w_span    = DEN_W'(i_track_span);
        w_den_in  = w_r2 - w_span;
        w_den_out = w_r2 + w_span;
        w_num     = {i_wheel_base, 1'b0};
        n_inner   = start_lane(w_den_in, w_num);
        n_outer   = start_lane(w_den_out, w_num);
        n_zr      = (i_radius == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zr    <= n_zr;
            r_inner <= n_inner;
            r_outer <= n_outer;
        end
    end

    always_comb begin
        o_stage.valid = r_valid;
        o_stage.zr    = r_zr;
        o_stage.inner = r_inner;
        o_stage.outer = r_outer;
    end

endmodule

// ===== hw/rtl/asa_cordic_stage.sv =====
`timescale 1ns / 1ps

module asa_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  asa_pkg::t_cstage i_stage,
    output asa_pkg::t_cstage o_stage
);
    import asa_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_entry(STEP));

    logic  r_valid;
    logic  r_zr;
    t_lane r_inner;
    t_lane r_outer;

    // One vectoring iteration; arithmetic right shifts floor toward minus infinity.
    function automatic t_lane rotate(input t_lane a);
        t_lane b;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        xs = $signed(a.x) >>> STEP;
        ys = $signed(a.y) >>> STEP;
        b  = a;
        if (!a.y[XY_W-1]) begin
            b.x = $signed(a.x) + ys;
            b.y = $signed(a.y) - xs;
            b.z = $signed(a.z) + ATAN;
        end else begin
            b.x = $signed(a.x) - ys;
            b.y = $signed(a.y) + xs;
            b.z = $signed(a.z) - ATAN;
        end
        return b;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zr    <= i_stage.zr;
            r_inner <= rotate(i_stage.inner);
            r_outer <= rotate(i_stage.outer);
        end
    end

    always_comb begin
        o_stage.valid = r_valid;
        o_stage.zr    = r_zr;
        o_stage.inner = r_inner;
        o_stage.outer = r_outer;
    end

endmodule

// ===== hw/rtl/asa_finish.sv =====
`timescale 1ns / 1ps

module asa_finish (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  asa_pkg::t_cstage i_stage,
    output asa_pkg::t_fin    o_fin
);
    import asa_pkg::*;

    logic  r_valid;
    logic  r_zr;
    t_cent r_inner;
    t_cent r_outer;

    // Clamp the angle to 0..90 degrees and round it to 0.01 degree, halves up.
    function automatic t_cent to_cent(input t_lane a);
        t_cent c;
        logic [ZC_W-1:0]   zc;
        logic [PROD_W-1:0] sum;
        logic [CENT_W-1:0] cent;
        if (a.z[Z_W-1]) begin
            zc = '0;
        end else if (a.z[Z_W-2:0] > (Z_W-1)'(Z_MAX)) begin
            zc = Z_MAX;
        end else begin
            zc = a.z[ZC_W-1:0];
        end
        sum  = PROD_W'(zc) * CENT_SCALE + ROUND_HALF;
        cent = sum[ANG_FRAC +: CENT_W];
        c.cent  = (cent > CENT_MAX) ? CENT_MAX : cent;
        c.neg   = a.neg;
        c.dzero = a.dzero;
        return c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zr    <= i_stage.zr;
            r_inner <= to_cent(i_stage.inner);
            r_outer <= to_cent(i_stage.outer);
        end
    end

    always_comb begin
        o_fin.valid = r_valid;
        o_fin.zr    = r_zr;
        o_fin.inner = r_inner;
        o_fin.outer = r_outer;
    end

endmodule

// ===== hw/rtl/ackermann_steering_angles_unit.sv =====
`timescale 1ns / 1ps
// Ackermann steering angle unit.
// The slave stream carries a signed turning radius in 0.1 mm on s_axis_tdata.
// For each radius the master stream returns the inner and outer wheel angles,
// atan(2L/(2R-T)) and atan(2L/(2R+T)) in 0.01 degree, their difference, and a
// zero-radius flag on m_axis_tuser (angles are then zero). A zero denominator
// gives +90.00 degrees. The user writes wheelbase L and track span T through
// the cfg port (index 0 and 1) only while no transaction is in flight; the
// block itself does not enforce this. The pipeline has a stage that forms the
// denominators, one pipeline stage per CORDIC iteration, a stage that rounds to
// 0.01 degree and an output register that applies sign and difference. Both
// angles run in parallel lanes, so one transaction is accepted every cycle unless
// the receiver stalls. Reset empties the pipeline and loads L = 3000 and T = 2000.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready drops; nothing in flight is lost or repeated, and as soon as the
// result is taken the pipeline moves again in that same cycle.

module ackermann_steering_angles_unit #(
    parameter int CORDIC_STEPS = asa_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [23:0] radius
    input  logic [asa_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [14:0] inner_angle, [29:15] outer_angle, [45:30] angle_gap, [47:46] zero
    output logic [asa_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // [0] zero_radius
    output logic                             m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [asa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [asa_pkg::REG_W-1:0]        i_cfg_data
);
    import asa_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    logic [REG_W-1:0] r_wheel_base;
    logic [REG_W-1:0] r_track_span;

    logic                       w_en;
    t_cstage                    w_chain [0:NSTEPS];
    t_fin                       w_fin;
    logic signed [ANGLE_W-1:0]  n_inner;
    logic signed [ANGLE_W-1:0]  n_outer;
    logic signed [GAP_W-1:0]    n_gap;

    logic                       r_m_valid;
    logic                       r_zr;
    logic signed [ANGLE_W-1:0]  r_inner;
    logic signed [ANGLE_W-1:0]  r_outer;
    logic signed [GAP_W-1:0]    r_gap;

    function automatic logic signed [ANGLE_W-1:0] signed_angle(input t_cent c);
        logic signed [ANGLE_W-1:0] a;
        if (c.dzero) begin
            a = ANGLE_W'(CENT_MAX);
        end else if (c.neg) begin
            a = -$signed(ANGLE_W'(c.cent));
        end else begin
            a = ANGLE_W'(c.cent);
        end
        return a;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_base <= WHEEL_BASE_RST;
            r_track_span <= TRACK_SPAN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WHEEL_BASE: r_wheel_base <= i_cfg_data;
                REG_TRACK_SPAN: r_track_span <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline advances unless a result is waiting on a stalled receiver.
    assign w_en          = !r_m_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    asa_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (s_axis_tvalid),
        .i_radius     ($signed(s_axis_tdata[RADIUS_W-1:0])),
        .i_wheel_base (r_wheel_base),
        .i_track_span (r_track_span),
        .o_stage      (w_chain[0])
    );

    for (genvar k = 0; k < NSTEPS; k++) begin : g_cordic
        asa_cordic_stage #(
            .STEP (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_chain[k]),
            .o_stage (w_chain[k+1])
        );
    end

    asa_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_stage (w_chain[NSTEPS]),
        .o_fin   (w_fin)
    );

    always_comb begin
        if (w_fin.zr) begin
            n_inner = '0;
            n_outer = '0;
        end else begin
            n_inner = signed_angle(w_fin.inner);
            n_outer = signed_angle(w_fin.outer);
        end
        n_gap = GAP_W'(n_inner) - GAP_W'(n_outer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= w_fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zr    <= w_fin.zr;
            r_inner <= n_inner;
            r_outer <= n_outer;
            r_gap   <= n_gap;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_zr;
    assign m_axis_tdata  = {2'b00, r_gap, r_outer, r_inner};

    a_zero_radius_angles : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_zr) |-> (r_inner == '0 && r_outer == '0 && r_gap == '0))
        else $error("zero radius result carries nonzero angles");

    a_gap_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_gap == GAP_W'(r_inner) - GAP_W'(r_outer)))
        else $error("angle gap does not match inner minus outer");

    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_inner <= $signed(ANGLE_W'(CENT_MAX))
                       && r_inner >= -$signed(ANGLE_W'(CENT_MAX))
                       && r_outer <= $signed(ANGLE_W'(CENT_MAX))
                       && r_outer >= -$signed(ANGLE_W'(CENT_MAX))))
        else $error("steering angle beyond 90 degrees");

endmodule
